>>> rtl/rcbm_pkg.sv
// Shared constants for the run-coalescing bracket matcher.
// Holds symbol, command, error and run-kind codes and default parameter values.
// No dependencies.
`default_nettype none

package rcbm_pkg;

  // default parameter values
  localparam int unsigned STACK_DEPTH_DEF   = 256;
  localparam int unsigned COUNT_WIDTH_DEF   = 16;
  localparam int unsigned LOOP_ID_WIDTH_DEF = 16;

  // source symbols
  localparam logic [7:0] SYM_PLUS   = 8'h2B;
  localparam logic [7:0] SYM_MINUS  = 8'h2D;
  localparam logic [7:0] SYM_LEFT   = 8'h3C;
  localparam logic [7:0] SYM_RIGHT  = 8'h3E;
  localparam logic [7:0] SYM_OUTPUT = 8'h2E;
  localparam logic [7:0] SYM_INPUT  = 8'h2C;
  localparam logic [7:0] SYM_OPEN   = 8'h5B;
  localparam logic [7:0] SYM_CLOSE  = 8'h5D;

  // command codes
  localparam logic [3:0] CMD_ADD    = 4'd0;
  localparam logic [3:0] CMD_SUB    = 4'd1;
  localparam logic [3:0] CMD_LEFT   = 4'd2;
  localparam logic [3:0] CMD_RIGHT  = 4'd3;
  localparam logic [3:0] CMD_OUTPUT = 4'd4;
  localparam logic [3:0] CMD_INPUT  = 4'd5;
  localparam logic [3:0] CMD_OPEN   = 4'd6;
  localparam logic [3:0] CMD_CLOSE  = 4'd7;
  localparam logic [3:0] CMD_ERROR  = 4'd8;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNMATCHED = 2'd1;
  localparam logic [1:0] ERR_UNCLOSED  = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

  // pending run kinds; command of a run is kind minus one
  localparam logic [2:0] RUN_NONE  = 3'd0;
  localparam logic [2:0] RUN_ADD   = 3'd1;
  localparam logic [2:0] RUN_SUB   = 3'd2;
  localparam logic [2:0] RUN_LEFT  = 3'd3;
  localparam logic [2:0] RUN_RIGHT = 3'd4;

  function automatic logic [2:0] run_kind_of(input logic [7:0] sym);
    logic [2:0] kind;
    case (sym)
      SYM_PLUS:  kind = RUN_ADD;
      SYM_MINUS: kind = RUN_SUB;
      SYM_LEFT:  kind = RUN_LEFT;
      SYM_RIGHT: kind = RUN_RIGHT;
      default:   kind = RUN_NONE;
    endcase
    return kind;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rcbm_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies; contents are not reset.
`default_nettype none

module rcbm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/run_coalescing_bracket_matcher_top.sv
// Top level of the run-coalescing bracket matcher.
// Depends on rcbm_pkg and rcbm_ram (open-bracket stack storage).
`default_nettype none

// Command frontend: one source byte per transfer in, coalesced commands out.
// Runs of '+', '-', '<', '>' merge into one command with a count; a run is
// emitted when another command character arrives, when it reaches its
// maximum count (the new run then restarts at 1), or at end of stream
// (tlast on the input). '[' emits an open command carrying its ordinal and
// pushes it; ']' pops it and emits a close with the same ordinal. Errors
// (unmatched close, nesting overflow) are sticky: everything up to end of
// stream is then dropped; loops left open are reported at end of stream,
// and end of stream returns the block to its reset state. Each input byte
// yields zero, one or two commands; the last one of them carries tlast.
// Throughput is one input transfer per cycle: the whole decision is taken
// in the accept cycle, the top of the bracket stack sits in a register, and
// the entry below it is prefetched from the stack RAM with write forwarding,
// so back-to-back pushes and pops never stall. Results drain through a
// four-entry queue at one command per cycle while the sink is ready; input
// tready drops only while that queue holds more than two commands, i.e.
// when bytes that make two commands arrive faster than the sink takes them.
// The stack RAM needs no clearing after reset.
module run_coalescing_bracket_matcher_top
  import rcbm_pkg::*;
#(
  parameter int unsigned STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int unsigned COUNT_WIDTH   = COUNT_WIDTH_DEF,
  parameter int unsigned LOOP_ID_WIDTH = LOOP_ID_WIDTH_DEF,
  localparam int unsigned OUT_BITS     = 6 + COUNT_WIDTH + LOOP_ID_WIDTH,
  localparam int unsigned OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [7:0]             s_axis_tdata_i,  // [7:0] symbol
  input  wire logic                   s_axis_tlast_i,  // end_of_stream
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // from bit 0: command(4), count(COUNT_WIDTH), loop_id(LOOP_ID_WIDTH),
  // error_code(2), zero padding
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  output logic                        m_axis_tlast_o   // last
);

  localparam int unsigned DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW      = $clog2(STACK_DEPTH);
  localparam int unsigned CW      = COUNT_WIDTH;
  localparam int unsigned LW      = LOOP_ID_WIDTH;
  localparam int unsigned ENTRY_W = OUT_BITS + 1;  // payload plus last flag
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QAW     = $clog2(QDEPTH);

  // ---------------------------------------------------------------------------
  // Frontend state
  // ---------------------------------------------------------------------------
  logic [2:0]         run_kind_q, run_kind_d;
  logic [CW-1:0]      run_count_q, run_count_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [LW-1:0]      tos_q, tos_d;        // top of stack, held outside the RAM
  logic [LW-1:0]      next_id_q, next_id_d;
  logic               err_q, err_d;
  logic               fwd_q;               // RAM read hit the entry just written
  logic [LW-1:0]      fwd_data_q;

  logic               in_fire;
  logic [7:0]         sym;
  logic [2:0]         sym_kind;
  logic               run_pending;
  logic               run_full;

  // stack RAM ports
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [DEPTH_W-1:0] raddr_full;
  logic [DEPTH_W-1:0] waddr_full;
  logic [LW-1:0]      ram_rdata;
  logic [LW-1:0]      below_tos;

  // up to two results per transfer: a flushed run, then a main command
  logic               flush_v;
  logic               main_v;
  logic [3:0]         main_cmd;
  logic [LW-1:0]      main_id;
  logic [1:0]         main_err;
  logic [OUT_BITS-1:0] flush_word;
  logic [OUT_BITS-1:0] main_word;

  assign in_fire     = s_axis_tvalid_i & s_axis_tready_o;
  assign sym         = s_axis_tdata_i;
  assign sym_kind    = run_kind_of(sym);
  assign run_pending = (run_kind_q != RUN_NONE);
  assign run_full    = (run_count_q == {CW{1'b1}});
  assign below_tos   = fwd_q ? fwd_data_q : ram_rdata;
  assign waddr_full  = depth_q - DEPTH_W'(1);
  assign ram_waddr   = waddr_full[AW-1:0];

  always_comb begin
    run_kind_d  = run_kind_q;
    run_count_d = run_count_q;
    depth_d     = depth_q;
    tos_d       = tos_q;
    next_id_d   = next_id_q;
    err_d       = err_q;
    ram_we      = 1'b0;
    flush_v     = 1'b0;
    main_v      = 1'b0;
    main_cmd    = CMD_ERROR;
    main_id     = '0;
    main_err    = ERR_NONE;

    if (in_fire) begin
      if (s_axis_tlast_i) begin
        // end of stream: flush and check unless an error already stopped us
        if (!err_q) begin
          flush_v = run_pending;
          if (depth_q != '0) begin
            main_v   = 1'b1;
            main_cmd = CMD_ERROR;
            main_err = ERR_UNCLOSED;
          end
        end
        run_kind_d  = RUN_NONE;
        run_count_d = '0;
        depth_d     = '0;
        next_id_d   = '0;
        err_d       = 1'b0;
      end else if (!err_q) begin
        if (sym_kind != RUN_NONE) begin
          // extend the run, or flush and start a new one at 1
          if (sym_kind != run_kind_q || run_full) begin
            flush_v     = run_pending;
            run_count_d = CW'(1);
          end else begin
            run_count_d = run_count_q + CW'(1);
          end
          run_kind_d = sym_kind;
        end else begin
          case (sym)
            SYM_OUTPUT, SYM_INPUT: begin
              flush_v     = run_pending;
              run_kind_d  = RUN_NONE;
              run_count_d = '0;
              main_v      = 1'b1;
              main_cmd    = (sym == SYM_OUTPUT) ? CMD_OUTPUT : CMD_INPUT;
            end
            SYM_OPEN: begin
              flush_v     = run_pending;
              run_kind_d  = RUN_NONE;
              run_count_d = '0;
              main_v      = 1'b1;
              if (depth_q == DEPTH_W'(STACK_DEPTH)) begin
                main_cmd = CMD_ERROR;
                main_err = ERR_OVERFLOW;
                err_d    = 1'b1;
              end else begin
                // spill the old top into the RAM, new ordinal becomes top
                ram_we    = (depth_q != '0);
                tos_d     = next_id_q;
                depth_d   = depth_q + DEPTH_W'(1);
                next_id_d = next_id_q + LW'(1);
                main_cmd  = CMD_OPEN;
                main_id   = next_id_q;
              end
            end
            SYM_CLOSE: begin
              flush_v     = run_pending;
              run_kind_d  = RUN_NONE;
              run_count_d = '0;
              main_v      = 1'b1;
              if (depth_q == '0) begin
                main_cmd = CMD_ERROR;
                main_err = ERR_UNMATCHED;
                err_d    = 1'b1;
              end else begin
                // pop: the prefetched entry below becomes the top
                tos_d    = below_tos;
                depth_d  = depth_q - DEPTH_W'(1);
                main_cmd = CMD_CLOSE;
                main_id  = tos_q;
              end
            end
            default: begin
              // other bytes are ignored and keep the run
            end
          endcase
        end
      end
    end
  end

  // Prefetch the entry below the next top of stack.
  assign raddr_full = depth_d - DEPTH_W'(2);
  assign ram_raddr  = raddr_full[AW-1:0];

  rcbm_ram #(
    .WIDTH(LW),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(tos_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_kind_q  <= RUN_NONE;
      run_count_q <= '0;
      depth_q     <= '0;
      next_id_q   <= '0;
      err_q       <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      run_kind_q  <= run_kind_d;
      run_count_q <= run_count_d;
      depth_q     <= depth_d;
      next_id_q   <= next_id_d;
      err_q       <= err_d;
      fwd_q       <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q      <= tos_d;
    fwd_data_q <= tos_q;
  end

  // ---------------------------------------------------------------------------
  // Result packing: {error_code, loop_id, count, command}
  // ---------------------------------------------------------------------------
  assign flush_word = {ERR_NONE, LW'(0), run_count_q, 4'(run_kind_q) - 4'd1};
  assign main_word  = {main_err, main_id, CW'(1), main_cmd};

  // ---------------------------------------------------------------------------
  // Output queue: up to two writes, one read per cycle
  // ---------------------------------------------------------------------------
  logic [ENTRY_W-1:0] q_mem_q [QDEPTH];
  logic [QAW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QAW:0]       q_cnt_q;
  logic [1:0]         n_push;
  logic               q_pop;
  logic [ENTRY_W-1:0] entry_a;
  logic [ENTRY_W-1:0] entry_b;
  logic [ENTRY_W-1:0] q_head;

  assign n_push  = {1'b0, flush_v} + {1'b0, main_v};
  assign entry_a = flush_v ? {~main_v, flush_word} : {1'b1, main_word};
  assign entry_b = {1'b1, main_word};
  assign q_pop   = m_axis_tvalid_o & m_axis_tready_i;

  // accept while two free slots remain
  assign s_axis_tready_o = (q_cnt_q <= (QAW+1)'(QDEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      q_mem_q[wr_ptr_q] <= entry_a;
    end
    if (n_push == 2'd2) begin
      q_mem_q[wr_ptr_q + QAW'(1)] <= entry_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QAW'(n_push);
      rd_ptr_q <= rd_ptr_q + QAW'(q_pop);
      q_cnt_q  <= q_cnt_q + (QAW+1)'(n_push) - (QAW+1)'(q_pop);
    end
  end

  assign q_head          = q_mem_q[rd_ptr_q];
  assign m_axis_tvalid_o = (q_cnt_q != '0);
  assign m_axis_tdata_o  = OUT_TDATA_W'(q_head[OUT_BITS-1:0]);
  assign m_axis_tlast_o  = q_head[OUT_BITS];

endmodule

`default_nettype wire

>>> bench/run_coalescing_bracket_matcher_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for run_coalescing_bracket_matcher_top: streams program
// bytes in, predicts the coalesced command stream, compares every result.
// Depends on rcbm_pkg and the matcher RTL (default parameters).
module run_coalescing_bracket_matcher_top_tb;
  import rcbm_pkg::*;

  localparam int unsigned DEPTH        = STACK_DEPTH_DEF;
  localparam int unsigned CW           = COUNT_WIDTH_DEF;
  localparam int unsigned IW           = LOOP_ID_WIDTH_DEF;
  localparam int unsigned RES_BITS     = 6 + CW + IW;
  localparam int unsigned TDATA_W      = ((RES_BITS + 7) / 8) * 8;
  localparam logic [CW-1:0] COUNT_MAX  = '1;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned PHASE_ITEMS  = 250;

  typedef struct packed {
    logic [3:0]    command;
    logic [CW-1:0] count;
    logic [IW-1:0] loop_id;
    logic [1:0]    error_code;
    logic          last;
  } cmd_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata;   // [7:0] symbol
  logic               s_axis_tlast;   // end_of_stream
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  // from bit 0: command(4), count(CW), loop_id(IW), error_code(2), zero padding
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tlast;   // last

  run_coalescing_bracket_matcher_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // bytes waiting for the driver: {end_of_stream, symbol}
  logic [8:0]  program_bytes [$];
  cmd_t        expected_cmds [$];
  int unsigned n_queued;
  int unsigned n_accepted;
  int unsigned n_failures;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          in_taken;

  // predictor copy of the frontend state
  logic [2:0]    pend_kind;
  logic [CW-1:0] pend_count;
  int unsigned   open_depth;
  logic [IW-1:0] open_ids [DEPTH];
  logic [IW-1:0] next_id;
  bit            in_error;

  function automatic cmd_t mk_cmd(input logic [3:0] c, input logic [CW-1:0] n,
                                  input logic [IW-1:0] id, input logic [1:0] e);
    return cmd_t'{command: c, count: n, loop_id: id, error_code: e, last: 1'b0};
  endfunction

  // Emit the pending run as a command and drop it.
  function automatic cmd_t take_run();
    logic [3:0] c;
    case (pend_kind)
      RUN_ADD:  c = CMD_ADD;
      RUN_SUB:  c = CMD_SUB;
      RUN_LEFT: c = CMD_LEFT;
      default:  c = CMD_RIGHT;
    endcase
    take_run   = mk_cmd(c, pend_count, '0, ERR_NONE);
    pend_kind  = RUN_NONE;
    pend_count = '0;
  endfunction

  function automatic void clear_frontend();
    pend_kind  = RUN_NONE;
    pend_count = '0;
    open_depth = 0;
    next_id    = '0;
    in_error   = 1'b0;
  endfunction

  // Work out the commands one accepted byte causes and queue them.
  function automatic void predict_commands(input logic [7:0] sym, input logic eos);
    cmd_t       res [2];
    int         n;
    logic [2:0] kind;
    n = 0;
    if (eos) begin
      if (!in_error) begin
        if (pend_kind != RUN_NONE) begin
          res[n] = take_run();
          n++;
        end
        if (open_depth != 0) begin
          res[n] = mk_cmd(CMD_ERROR, CW'(1), '0, ERR_UNCLOSED);
          n++;
        end
      end
      clear_frontend();
    end else if (!in_error) begin
      case (sym)
        SYM_PLUS:  kind = RUN_ADD;
        SYM_MINUS: kind = RUN_SUB;
        SYM_LEFT:  kind = RUN_LEFT;
        SYM_RIGHT: kind = RUN_RIGHT;
        default:   kind = RUN_NONE;
      endcase
      if (kind != RUN_NONE) begin
        // a different kind or a full run closes the pending one
        if (kind != pend_kind || pend_count == COUNT_MAX) begin
          if (pend_kind != RUN_NONE) begin
            res[n] = take_run();
            n++;
          end
          pend_count = '0;
        end
        pend_kind  = kind;
        pend_count = pend_count + 1'b1;
      end else if (sym == SYM_OUTPUT || sym == SYM_INPUT || sym == SYM_OPEN ||
                   sym == SYM_CLOSE) begin
        if (pend_kind != RUN_NONE) begin
          res[n] = take_run();
          n++;
        end
        if (sym == SYM_OUTPUT) begin
          res[n] = mk_cmd(CMD_OUTPUT, CW'(1), '0, ERR_NONE);
        end else if (sym == SYM_INPUT) begin
          res[n] = mk_cmd(CMD_INPUT, CW'(1), '0, ERR_NONE);
        end else if (sym == SYM_OPEN) begin
          if (open_depth >= DEPTH) begin
            res[n]   = mk_cmd(CMD_ERROR, CW'(1), '0, ERR_OVERFLOW);
            in_error = 1'b1;
          end else begin
            open_ids[open_depth] = next_id;
            open_depth++;
            res[n]  = mk_cmd(CMD_OPEN, CW'(1), next_id, ERR_NONE);
            next_id = next_id + 1'b1;
          end
        end else begin
          if (open_depth == 0) begin
            res[n]   = mk_cmd(CMD_ERROR, CW'(1), '0, ERR_UNMATCHED);
            in_error = 1'b1;
          end else begin
            open_depth--;
            res[n] = mk_cmd(CMD_CLOSE, CW'(1), open_ids[open_depth], ERR_NONE);
          end
        end
        n++;
      end
    end
    if (n > 0) begin
      res[n-1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      expected_cmds.push_back(res[i]);
    end
  endfunction

  // Predict on every input transfer, check every output transfer, and watch
  // for a stuck handshake. Prediction runs first so that the order of the two
  // is fixed within the edge.
  always @(posedge clk_i) begin
    cmd_t got;
    cmd_t want;
    logic [TDATA_W-1:0] pad;
    bit out_taken;
    in_taken  = rst_ni && s_axis_tvalid && s_axis_tready;
    out_taken = rst_ni && m_axis_tvalid && m_axis_tready;
    if (in_taken) begin
      predict_commands(s_axis_tdata, s_axis_tlast);
      n_accepted++;
    end
    if (out_taken) begin
      got.command    = m_axis_tdata[3:0];
      got.count      = m_axis_tdata[4 +: CW];
      got.loop_id    = m_axis_tdata[4 + CW +: IW];
      got.error_code = m_axis_tdata[4 + CW + IW +: 2];
      got.last       = m_axis_tlast;
      pad            = m_axis_tdata >> RES_BITS;
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected result cmd=%0d count=%0d id=%0d err=%0d last=%0b",
                 $time, got.command, got.count, got.loop_id, got.error_code, got.last);
        n_failures++;
      end else begin
        want = expected_cmds.pop_front();
        if (got != want || pad != '0) begin
          $display("%0t: mismatch expected cmd=%0d count=%0d id=%0d err=%0d last=%0b pad=0",
                   $time, want.command, want.count, want.loop_id, want.error_code,
                   want.last);
          $display("%0t:          actual cmd=%0d count=%0d id=%0d err=%0d last=%0b pad=%0h",
                   $time, got.command, got.count, got.loop_id, got.error_code,
                   got.last, pad);
          n_failures++;
        end
      end
    end
    if (!rst_ni || in_taken || out_taken) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Present the next byte once the previous one is taken; idle and stall at
  // the rates of the current phase.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (program_bytes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          {s_axis_tlast, s_axis_tdata} <= program_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= $urandom_range(99, 0) >= recv_stall_pct;
    end
  end

  task automatic put_byte(input logic eos, input logic [7:0] sym);
    program_bytes.push_back({eos, sym});
    n_queued++;
  endtask

  // End of stream carries a random symbol, which the block must ignore.
  task automatic end_program();
    put_byte(1'b1, 8'($urandom_range(255, 0)));
  endtask

  // Hold off the sender until every byte is in and every result is out.
  task automatic settle();
    do begin
      @(negedge clk_i);
    end while (n_accepted != n_queued || expected_cmds.size() != 0);
    @(posedge clk_i);
  endtask

  // One program: mostly well formed with random content; a broken one may
  // close at depth zero or leave loops open.
  task automatic random_program(input int budget, input bit broken);
    int          depth;
    int          len;
    int unsigned pick;
    logic [7:0]  sym;
    depth = 0;
    while (budget > 0) begin
      pick = $urandom_range(99, 0);
      if (pick < 45) begin
        case ($urandom_range(3, 0))
          0:       sym = SYM_PLUS;
          1:       sym = SYM_MINUS;
          2:       sym = SYM_LEFT;
          default: sym = SYM_RIGHT;
        endcase
        len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 5) : $urandom_range(4, 1);
        repeat (len) put_byte(1'b0, sym);
        budget -= len;
      end else begin
        if (pick < 58) begin
          put_byte(1'b0, $urandom_range(1, 0) ? SYM_OUTPUT : SYM_INPUT);
        end else if (pick < 74 || (pick < 90 && depth == 0 && !broken)) begin
          put_byte(1'b0, depth < 60 ? SYM_OPEN : SYM_CLOSE);
          depth = depth < 60 ? depth + 1 : depth - 1;
        end else if (pick < 90) begin
          put_byte(1'b0, SYM_CLOSE);
          depth = depth > 0 ? depth - 1 : 0;
        end else begin
          // any byte, command characters included
          put_byte(1'b0, 8'($urandom_range(255, 0)));
        end
        budget--;
      end
    end
    if (!broken || $urandom_range(1, 0) == 0) begin
      repeat (depth) put_byte(1'b0, SYM_CLOSE);
    end
    end_program();
  endtask

  initial begin
    int unsigned idle_tab  [4];
    int unsigned stall_tab [4];
    int unsigned phase_start;
    idle_tab       = '{0, 86, 0, 38};
    stall_tab      = '{0, 0, 86, 38};
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    m_axis_tready  = 1'b0;
    n_queued       = 0;
    n_accepted     = 0;
    n_failures     = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    in_taken       = 1'b0;
    clear_frontend();
    for (int i = 0; i < DEPTH; i++) begin
      open_ids[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short directed part: every command, ignored bytes inside a run, extreme
    // byte values, unmatched close with a pending run, sticky error, loops
    // left open at end, and a bare end of stream.
    put_byte(1'b0, SYM_PLUS);
    put_byte(1'b0, SYM_PLUS);
    put_byte(1'b0, 8'h00);
    put_byte(1'b0, SYM_PLUS);
    put_byte(1'b0, SYM_MINUS);
    put_byte(1'b0, SYM_LEFT);
    put_byte(1'b0, 8'hFF);
    put_byte(1'b0, SYM_RIGHT);
    put_byte(1'b0, SYM_OUTPUT);
    put_byte(1'b0, SYM_INPUT);
    put_byte(1'b0, SYM_OPEN);
    put_byte(1'b0, SYM_LEFT);
    put_byte(1'b0, SYM_CLOSE);
    put_byte(1'b0, SYM_RIGHT);
    put_byte(1'b1, 8'hFF);
    put_byte(1'b0, SYM_PLUS);
    put_byte(1'b0, SYM_CLOSE);
    put_byte(1'b0, SYM_PLUS);
    put_byte(1'b0, SYM_OPEN);
    put_byte(1'b1, SYM_OUTPUT);
    put_byte(1'b0, SYM_OPEN);
    put_byte(1'b0, SYM_OPEN);
    put_byte(1'b0, SYM_MINUS);
    put_byte(1'b1, 8'h00);
    put_byte(1'b1, SYM_CLOSE);
    settle();

    // Fill the stack to the top, drain it, refill it and push once more.
    for (int i = 0; i < DEPTH; i++) begin
      put_byte(1'b0, SYM_OPEN);
      if (i % 7 == 0) begin
        put_byte(1'b0, SYM_RIGHT);
      end
    end
    repeat (DEPTH) put_byte(1'b0, SYM_CLOSE);
    repeat (DEPTH) put_byte(1'b0, SYM_OPEN);
    put_byte(1'b0, SYM_LEFT);
    put_byte(1'b0, SYM_OPEN);
    put_byte(1'b0, SYM_CLOSE);
    end_program();
    settle();

    // Random part, one phase per idle pattern; drain fully between phases
    // and now and then in the middle of one.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_tab[p];
      recv_stall_pct = stall_tab[p];
      phase_start    = n_queued;
      while (n_queued - phase_start < PHASE_ITEMS) begin
        random_program($urandom_range(60, 3), $urandom_range(5, 0) == 0);
        if ($urandom_range(7, 0) == 0) begin
          settle();
        end
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_failures == 0 && expected_cmds.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
